FILE: design/tsur_pkg.sv
// Shared types, constants and helper functions for the tissue solute uptake block.
// Used by the front end, the back end and the top level; depends on nothing else.
package tsur_pkg;

  // Field widths.
  localparam int unsigned LevelW = 32;
  localparam int unsigned CoefW  = 31;
  localparam int unsigned SpanW  = 21;
  localparam int unsigned RampW  = 19;

  // Long-division geometry: divisor width, quotient bits and dividend width.
  localparam int unsigned DenW = 32;
  localparam int unsigned QuoW = 47;
  localparam int unsigned NumW = 78;

  // Oxygen breakpoints of the VEGF production curve, Q16.16.
  localparam logic signed [LevelW-1:0] LowOxygen  = 32'sd65536;
  localparam logic signed [LevelW-1:0] HighOxygen = 32'sd1310720;

  // Reciprocal of the ramp divisor 19^3 = 6859, scaled by 2^44 and rounded up.
  // The ramp dividend stays below 2^31.1, where this reciprocal gives the exact floor.
  localparam logic [DenW-1:0] RampRecip = 32'd2564832490;
  localparam int unsigned     RampShift = 44;

  // Largest solute count that is evaluated.
  localparam logic [2:0] MaxCount = 3'd4;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    RegSoluteCount      = 3'd0,
    RegOxygenMaxRate    = 3'd1,
    RegOxygenHalfLevel  = 3'd2,
    RegVegfBaseRate     = 3'd3,
    RegVegfDecay        = 3'd4,
    RegLinearDecay      = 3'd5,
    RegHypoxicProdution = 3'd6,
    RegHypoxicDecay     = 3'd7
  } cfg_idx_e;

  // Oxygen region of the VEGF production curve.
  typedef enum logic [1:0] {
    RegionPeak = 2'd0,
    RegionRamp = 2'd1,
    RegionFlat = 2'd2
  } region_e;

  typedef struct packed {
    logic [2:0]       solute_count;
    logic [CoefW-1:0] oxygen_max_rate;
    logic [CoefW-1:0] oxygen_half_level;
    logic [CoefW-1:0] vegf_base_rate;
    logic [CoefW-1:0] vegf_decay;
    logic [CoefW-1:0] linear_decay;
    logic [CoefW-1:0] hypoxic_production;
    logic [CoefW-1:0] hypoxic_decay;
  } cfg_t;

  // Classified input word as it sits in the queue between front and back.
  typedef struct packed {
    logic signed [LevelW-1:0] oxygen_level;
    logic signed [LevelW-1:0] vegf_level;
    logic signed [LevelW-1:0] linear_level;
    logic signed [LevelW-1:0] hypoxic_level;
    logic [DenW-1:0]          den;
    logic [SpanW-1:0]         span;
    region_e                  region;
    logic                     oxy_neg;
  } front_item_t;

  typedef struct packed {
    logic signed [LevelW-1:0] oxygen_rate;
    logic signed [LevelW-1:0] oxygen_slope;
    logic signed [LevelW-1:0] vegf_rate;
    logic signed [LevelW-1:0] vegf_slope;
    logic signed [LevelW-1:0] linear_rate;
    logic signed [LevelW-1:0] linear_slope;
    logic signed [LevelW-1:0] hypoxic_rate;
    logic signed [LevelW-1:0] hypoxic_slope;
  } result_t;

  // A half level of zero acts as one LSB.
  function automatic logic [CoefW-1:0] half_eff(input cfg_t cfg);
    half_eff = (cfg.oxygen_half_level == '0) ? CoefW'(1) : cfg.oxygen_half_level;
  endfunction

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [LevelW-1:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -50'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[LevelW-1:0];
    end
  endfunction

endpackage

FILE: design/tsur_fifo.sv
// Small first-in first-out queue of generic width.
// Used for the front-to-back queue and the result queue; needs no package.
module tsur_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/tsur_front.sv
// Front end: classifies one tissue point before it enters the queue.
// Depends on tsur_pkg for the configuration and queue word types.
module tsur_front
  import tsur_pkg::*;
(
  input  cfg_t                     cfg_i,
  input  logic signed [LevelW-1:0] oxygen_level_i,
  input  logic signed [LevelW-1:0] vegf_level_i,
  input  logic signed [LevelW-1:0] linear_level_i,
  input  logic signed [LevelW-1:0] hypoxic_level_i,
  output front_item_t              item_o
);

  logic [CoefW-1:0] kk;
  logic             neg;

  assign kk  = half_eff(cfg_i);
  assign neg = oxygen_level_i[LevelW-1];

  // Oxygen denominator and VEGF region with its distance to the upper breakpoint.
  always_comb begin
    item_o.oxygen_level  = oxygen_level_i;
    item_o.vegf_level    = vegf_level_i;
    item_o.linear_level  = linear_level_i;
    item_o.hypoxic_level = hypoxic_level_i;
    item_o.oxy_neg       = neg;
    item_o.den = neg ? DenW'(kk) : DenW'(oxygen_level_i[LevelW-2:0]) + DenW'(kk);
    item_o.span = '0;
    if (oxygen_level_i <= LowOxygen) begin
      item_o.region = RegionPeak;
    end else if (oxygen_level_i <= HighOxygen) begin
      item_o.region = RegionRamp;
      item_o.span   = SpanW'(HighOxygen - oxygen_level_i);
    end else begin
      item_o.region = RegionFlat;
    end
  end

endmodule

FILE: design/tsur_div.sv
// Pipelined restoring divider: one quotient bit per stage, several lanes abreast,
// with a sideband word that travels alongside. Needs no package.
module tsur_div #(
  parameter int unsigned Lanes = 1,
  parameter int unsigned NumW  = 78,
  parameter int unsigned DenW  = 32,
  parameter int unsigned QuoW  = 47,
  parameter int unsigned SideW = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [Lanes-1:0][NumW-1:0]       num_i,
  input  logic [Lanes-1:0][DenW-1:0]       den_i,
  input  logic [SideW-1:0]                 side_i,
  output logic                             valid_o,
  output logic [Lanes-1:0][QuoW-1:0]       quo_o,
  output logic [SideW-1:0]                 side_o
);

  // Stage inputs: index 0 is the port, index s+1 the register of stage s.
  logic [Lanes-1:0][DenW-1:0] rem_c [QuoW+1];
  logic [Lanes-1:0][QuoW-1:0] low_c [QuoW+1];
  logic [Lanes-1:0][QuoW-1:0] quo_c [QuoW+1];
  logic [Lanes-1:0][DenW-1:0] den_c [QuoW+1];
  logic [SideW-1:0]           side_c [QuoW+1];
  logic [QuoW:0]              vld_c;

  logic [Lanes-1:0][DenW-1:0] rem_d [QuoW];
  logic [Lanes-1:0][QuoW-1:0] low_d [QuoW];
  logic [Lanes-1:0][QuoW-1:0] quo_d [QuoW];
  logic [Lanes-1:0][DenW-1:0] rem_q [QuoW];
  logic [Lanes-1:0][QuoW-1:0] low_q [QuoW];
  logic [Lanes-1:0][QuoW-1:0] quo_q [QuoW];
  logic [Lanes-1:0][DenW-1:0] den_q [QuoW];
  logic [SideW-1:0]           side_q [QuoW];
  logic [QuoW-1:0]            vld_q;

  // The upper dividend bits are already below the divisor and seed the remainder.
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      rem_c[0][l] = DenW'(num_i[l][NumW-1:QuoW]);
      low_c[0][l] = num_i[l][QuoW-1:0];
      quo_c[0][l] = '0;
      den_c[0][l] = den_i[l];
    end
    side_c[0] = side_i;
    vld_c[0]  = valid_i;
    for (int s = 0; s < QuoW; s++) begin
      rem_c[s+1]  = rem_q[s];
      low_c[s+1]  = low_q[s];
      quo_c[s+1]  = quo_q[s];
      den_c[s+1]  = den_q[s];
      side_c[s+1] = side_q[s];
      vld_c[s+1]  = vld_q[s];
    end
  end

  // One trial subtraction per stage and lane.
  always_comb begin
    logic [DenW:0] tr;
    logic          ge;
    for (int s = 0; s < QuoW; s++) begin
      for (int l = 0; l < Lanes; l++) begin
        tr = {rem_c[s][l], low_c[s][l][QuoW-1]};
        ge = (tr >= {1'b0, den_c[s][l]});
        rem_d[s][l] = ge ? DenW'(tr - {1'b0, den_c[s][l]}) : tr[DenW-1:0];
        low_d[s][l] = low_c[s][l] << 1;
        quo_d[s][l] = {quo_c[s][l][QuoW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_c[QuoW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QuoW; s++) begin
        rem_q[s]  <= rem_d[s];
        low_q[s]  <= low_d[s];
        quo_q[s]  <= quo_d[s];
        den_q[s]  <= den_c[s];
        side_q[s] <= side_c[s];
      end
    end
  end

  assign valid_o = vld_c[QuoW];
  assign quo_o   = quo_c[QuoW];
  assign side_o  = side_c[QuoW];

endmodule

FILE: design/tsur_back.sv
// Back end: multiplier stages, two divider pipelines and the rate assembly.
// Depends on tsur_pkg and tsur_div; the whole pipeline stalls while the result queue is full.
module tsur_back
  import tsur_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  front_item_t item_i,
  input  logic        item_empty_i,
  output logic        item_pop_o,
  input  logic        res_full_i,
  output logic        res_push_o,
  output result_t     res_o
);

  typedef struct packed {
    logic [LevelW-1:0]  t;
    logic signed [47:0] vdq;
    logic signed [47:0] ldq;
    logic signed [47:0] hdq;
    region_e            region;
    logic               neg;
    logic [DenW-1:0]    den;
  } side1_t;

  typedef struct packed {
    logic [CoefW-1:0]   q0;
    logic [CoefW-1:0]   qh;
    logic [RampW-1:0]   ramp;
    logic signed [47:0] vdq;
    logic signed [47:0] ldq;
    logic signed [47:0] hdq;
    region_e            region;
    logic               neg;
  } side2_t;

  // Coefficient times level scaled back to Q16.16, truncated toward zero.
  function automatic logic signed [47:0] q_trunc(input logic signed [63:0] p);
    logic signed [63:0] b;
    b = p + (p[63] ? 64'sd65535 : 64'sd0);
    q_trunc = 48'(b >>> 16);
  endfunction

  logic             adv;
  logic [CoefW-1:0] kk;
  logic [CoefW-1:0] p1u;

  assign adv        = !res_full_i;
  assign item_pop_o = adv && !item_empty_i;
  assign kk         = half_eff(cfg_i);
  assign p1u        = item_i.oxy_neg ? '0 : item_i.oxygen_level[LevelW-2:0];

  // Stage 1: all first-level products.
  logic                 s1_v_q;
  logic [61:0]          s1_mp_q, s1_mk_q, s1_gk_q;
  logic [41:0]          s1_d2_q;
  logic signed [63:0]   s1_vd_q, s1_ld_q, s1_hd_q;
  logic [DenW-1:0]      s1_den_q;
  logic [SpanW-1:0]     s1_span_q;
  region_e              s1_region_q;
  logic                 s1_neg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mp_q     <= 62'(cfg_i.oxygen_max_rate) * 62'(p1u);
      s1_mk_q     <= 62'(cfg_i.oxygen_max_rate) * 62'(kk);
      s1_gk_q     <= 62'(cfg_i.hypoxic_production) * 62'(kk);
      s1_d2_q     <= 42'(item_i.span) * 42'(item_i.span);
      s1_vd_q     <= 64'($signed({1'b0, cfg_i.vegf_decay})) * 64'(item_i.vegf_level);
      s1_ld_q     <= 64'($signed({1'b0, cfg_i.linear_decay})) * 64'(item_i.linear_level);
      s1_hd_q     <= 64'($signed({1'b0, cfg_i.hypoxic_decay})) * 64'(item_i.hypoxic_level);
      s1_den_q    <= item_i.den;
      s1_span_q   <= item_i.span;
      s1_region_q <= item_i.region;
      s1_neg_q    <= item_i.oxy_neg;
    end
  end

  // Stage 2: cube of the ramp distance in two partial products, decay scaling.
  logic                 s2_v_q;
  logic [52:0]          s2_d3lo_q;
  logic [30:0]          s2_d3hi_q;
  logic [61:0]          s2_mp_q, s2_mk_q, s2_gk_q;
  logic signed [47:0]   s2_vdq_q, s2_ldq_q, s2_hdq_q;
  logic [DenW-1:0]      s2_den_q;
  region_e              s2_region_q;
  logic                 s2_neg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_d3lo_q   <= 53'(s1_d2_q[31:0]) * 53'(s1_span_q);
      s2_d3hi_q   <= 31'(s1_d2_q[41:32]) * 31'(s1_span_q);
      s2_mp_q     <= s1_mp_q;
      s2_mk_q     <= s1_mk_q;
      s2_gk_q     <= s1_gk_q;
      s2_vdq_q    <= q_trunc(s1_vd_q);
      s2_ldq_q    <= q_trunc(s1_ld_q);
      s2_hdq_q    <= q_trunc(s1_hd_q);
      s2_den_q    <= s1_den_q;
      s2_region_q <= s1_region_q;
      s2_neg_q    <= s1_neg_q;
    end
  end

  // Stage 3: five times the cube, upper word taken as the ramp dividend.
  logic [63:0]          d3, five;
  logic                 s3_v_q;
  logic [61:0]          s3_mp_q, s3_mk_q, s3_gk_q;
  side1_t               s3_side_q;

  assign d3   = 64'({s2_d3hi_q, 32'b0}) + 64'(s2_d3lo_q);
  assign five = (d3 << 2) + d3;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_mp_q          <= s2_mp_q;
      s3_mk_q          <= s2_mk_q;
      s3_gk_q          <= s2_gk_q;
      s3_side_q.t      <= five[63:32];
      s3_side_q.vdq    <= s2_vdq_q;
      s3_side_q.ldq    <= s2_ldq_q;
      s3_side_q.hdq    <= s2_hdq_q;
      s3_side_q.region <= s2_region_q;
      s3_side_q.neg    <= s2_neg_q;
      s3_side_q.den    <= s2_den_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= !item_empty_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // Divider bank: scaled M*K, M*p and G*K over the oxygen denominator.
  logic [2:0][NumW-1:0] bank_num;
  logic [2:0][DenW-1:0] bank_den;
  logic [2:0][QuoW-1:0] bank_quo;
  logic                 bank_v;
  side1_t               bank_side;

  assign bank_num[0] = {s3_mk_q, 16'b0};
  assign bank_num[1] = NumW'(s3_mp_q);
  assign bank_num[2] = NumW'(s3_gk_q);
  assign bank_den[0] = s3_side_q.den;
  assign bank_den[1] = s3_side_q.den;
  assign bank_den[2] = s3_side_q.den;

  tsur_div #(
    .Lanes(3),
    .NumW (NumW),
    .DenW (DenW),
    .QuoW (QuoW),
    .SideW($bits(side1_t))
  ) u_div_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(s3_v_q),
    .num_i  (bank_num),
    .den_i  (bank_den),
    .side_i (s3_side_q),
    .valid_o(bank_v),
    .quo_o  (bank_quo),
    .side_o (bank_side)
  );

  // Second division by the denominator gives the oxygen slope magnitude.
  logic [0:0][NumW-1:0] sl_num;
  logic [0:0][DenW-1:0] sl_den;
  logic [0:0][QuoW-1:0] sl_quo;
  logic                 sl_v;
  side2_t               sl_side_in, sl_side;
  logic [63:0]          ramp_full;

  assign sl_num[0] = NumW'(bank_quo[0]);
  assign sl_den[0] = bank_side.den;

  // The ramp dividend over 19^3 by multiplication with the scaled reciprocal.
  assign ramp_full = 64'(bank_side.t) * 64'(RampRecip);

  always_comb begin
    sl_side_in.q0     = bank_quo[1][CoefW-1:0];
    sl_side_in.qh     = bank_quo[2][CoefW-1:0];
    sl_side_in.ramp   = ramp_full[RampShift +: RampW];
    sl_side_in.vdq    = bank_side.vdq;
    sl_side_in.ldq    = bank_side.ldq;
    sl_side_in.hdq    = bank_side.hdq;
    sl_side_in.region = bank_side.region;
    sl_side_in.neg    = bank_side.neg;
  end

  tsur_div #(
    .Lanes(1),
    .NumW (NumW),
    .DenW (DenW),
    .QuoW (QuoW),
    .SideW($bits(side2_t))
  ) u_div_slope (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(bank_v),
    .num_i  (sl_num),
    .den_i  (sl_den),
    .side_i (sl_side_in),
    .valid_o(sl_v),
    .quo_o  (sl_quo),
    .side_o (sl_side)
  );

  // Finish 1: oxygen terms and the two production terms.
  logic                     f1_v_q;
  logic signed [LevelW-1:0] f1_r0_q, f1_r1_q;
  logic [35:0]              f1_prodv_q;
  logic [CoefW-1:0]         f1_prodh_q;
  logic signed [47:0]       f1_vdq_q, f1_ldq_q, f1_hdq_q;
  logic signed [LevelW-1:0] slope_c, rate_c;
  logic [35:0]              prodv_c;
  logic [49:0]              ramp_prod;

  assign ramp_prod = 50'(cfg_i.vegf_base_rate) * 50'(sl_side.ramp);

  always_comb begin
    if (sl_side.neg) begin
      rate_c  = '0;
      slope_c = '0;
    end else begin
      rate_c  = 32'sd0 - $signed({1'b0, sl_side.q0});
      slope_c = (sl_quo[0] >= QuoW'(32'h80000000)) ? 32'sh80000000 :
                LevelW'(32'sd0 - $signed(sl_quo[0][LevelW-1:0]));
    end
    case (sl_side.region)
      RegionPeak: prodv_c = (36'(cfg_i.vegf_base_rate) << 2) + (36'(cfg_i.vegf_base_rate) << 1);
      RegionRamp: prodv_c = 36'(cfg_i.vegf_base_rate) + 36'(ramp_prod >> 16);
      RegionFlat: prodv_c = 36'(cfg_i.vegf_base_rate);
      default:    prodv_c = 36'(cfg_i.vegf_base_rate);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_r0_q    <= rate_c;
      f1_r1_q    <= slope_c;
      f1_prodv_q <= prodv_c;
      f1_prodh_q <= sl_side.neg ? cfg_i.hypoxic_production : sl_side.qh;
      f1_vdq_q   <= sl_side.vdq;
      f1_ldq_q   <= sl_side.ldq;
      f1_hdq_q   <= sl_side.hdq;
    end
  end

  // Finish 2: net rates, saturation and masking by the solute count.
  logic                     f2_v_q;
  result_t                  f2_q, res_c;
  logic [2:0]               count;
  logic signed [49:0]       v2, v4, v6;

  assign count = (cfg_i.solute_count > MaxCount) ? MaxCount : cfg_i.solute_count;
  assign v2    = $signed({14'b0, f1_prodv_q}) - 50'(f1_vdq_q);
  assign v4    = 50'sd0 - 50'(f1_ldq_q);
  assign v6    = $signed({19'b0, f1_prodh_q}) - 50'(f1_hdq_q);

  always_comb begin
    res_c = '0;
    if (count >= 3'd1) begin
      res_c.oxygen_rate  = f1_r0_q;
      res_c.oxygen_slope = f1_r1_q;
    end
    if (count >= 3'd2) begin
      res_c.vegf_rate  = sat32(v2);
      res_c.vegf_slope = 32'sd0 - $signed({1'b0, cfg_i.vegf_decay});
    end
    if (count >= 3'd3) begin
      res_c.linear_rate  = sat32(v4);
      res_c.linear_slope = 32'sd0 - $signed({1'b0, cfg_i.linear_decay});
    end
    if (count >= 3'd4) begin
      res_c.hypoxic_rate  = sat32(v6);
      res_c.hypoxic_slope = 32'sd0 - $signed({1'b0, cfg_i.hypoxic_decay});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f2_q <= res_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else if (adv) begin
      f1_v_q <= sl_v;
      f2_v_q <= f1_v_q;
    end
  end

  assign res_push_o = f2_v_q && adv;
  assign res_o      = f2_q;

endmodule

FILE: design/tissue_solute_uptake_rates.sv
// Top level of the tissue solute uptake block: configuration registers, queues, front and back.
// Depends on tsur_pkg, tsur_fifo, tsur_front and tsur_back.
//
// Usage. Each word on the input queue (push/full) is one tissue point with four
// signed Q16.16 solute levels; it is taken at an edge with push high and full low.
// Each result word (empty/pop) holds a rate and a slope for each of the four solutes;
// the oldest one is on the ports while empty is low and is taken on pop.
// Configuration registers are written through cfg_valid_i/cfg_ready_o with an index
// and data; ready is always high. Write them only while no word is in flight.
// Throughput is one word per clock while the result queue is not full. On its way to
// the result queue a word passes the input queue entry, three multiplier stages, a 47-stage
// divider bank, a second 47-stage divider for the oxygen slope and two finishing stages.
// When the receiver stops popping, the result queue fills and the whole back
// pipeline holds in place; the input queue then fills and full goes high. Nothing is
// dropped. Reset empties both queues and the pipeline and loads the register defaults.
module tissue_solute_uptake_rates
  import tsur_pkg::*;
#(
  parameter int unsigned InDepth  = 2,
  parameter int unsigned OutDepth = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic signed [LevelW-1:0] oxygen_level_i,
  input  logic signed [LevelW-1:0] vegf_level_i,
  input  logic signed [LevelW-1:0] linear_level_i,
  input  logic signed [LevelW-1:0] hypoxic_level_i,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [LevelW-1:0] oxygen_rate_o,
  output logic signed [LevelW-1:0] oxygen_slope_o,
  output logic signed [LevelW-1:0] vegf_rate_o,
  output logic signed [LevelW-1:0] vegf_slope_o,
  output logic signed [LevelW-1:0] linear_rate_o,
  output logic signed [LevelW-1:0] linear_slope_o,
  output logic signed [LevelW-1:0] hypoxic_rate_o,
  output logic signed [LevelW-1:0] hypoxic_slope_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [2:0]               cfg_index_i,
  input  logic [31:0]              cfg_data_i
);

  cfg_t cfg_q;

  // Configuration register file.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.solute_count       <= MaxCount;
      cfg_q.oxygen_max_rate    <= '0;
      cfg_q.oxygen_half_level  <= CoefW'(65536);
      cfg_q.vegf_base_rate     <= '0;
      cfg_q.vegf_decay         <= '0;
      cfg_q.linear_decay       <= '0;
      cfg_q.hypoxic_production <= '0;
      cfg_q.hypoxic_decay      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        RegSoluteCount:      cfg_q.solute_count       <= cfg_data_i[2:0];
        RegOxygenMaxRate:    cfg_q.oxygen_max_rate    <= cfg_data_i[CoefW-1:0];
        RegOxygenHalfLevel:  cfg_q.oxygen_half_level  <= cfg_data_i[CoefW-1:0];
        RegVegfBaseRate:     cfg_q.vegf_base_rate     <= cfg_data_i[CoefW-1:0];
        RegVegfDecay:        cfg_q.vegf_decay         <= cfg_data_i[CoefW-1:0];
        RegLinearDecay:      cfg_q.linear_decay       <= cfg_data_i[CoefW-1:0];
        RegHypoxicProdution: cfg_q.hypoxic_production <= cfg_data_i[CoefW-1:0];
        RegHypoxicDecay:     cfg_q.hypoxic_decay      <= cfg_data_i[CoefW-1:0];
        default: ;
      endcase
    end
  end

  // Front end classifies the incoming word.
  front_item_t fe_item;

  tsur_front u_front (
    .cfg_i          (cfg_q),
    .oxygen_level_i (oxygen_level_i),
    .vegf_level_i   (vegf_level_i),
    .linear_level_i (linear_level_i),
    .hypoxic_level_i(hypoxic_level_i),
    .item_o         (fe_item)
  );

  // Queue between front and back.
  logic [$bits(front_item_t)-1:0] inq_data;
  logic                           inq_empty, inq_pop;

  tsur_fifo #(
    .Width($bits(front_item_t)),
    .Depth(InDepth)
  ) u_in_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (fe_item),
    .full_o (full),
    .pop_i  (inq_pop),
    .data_o (inq_data),
    .empty_o(inq_empty)
  );

  // Back end computes the rates.
  logic    res_full, res_push;
  result_t res_word;

  tsur_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (front_item_t'(inq_data)),
    .item_empty_i(inq_empty),
    .item_pop_o  (inq_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_word)
  );

  // Result queue decouples the back end from the receiver.
  logic [$bits(result_t)-1:0] outq_data;
  result_t                    out_word;

  tsur_fifo #(
    .Width($bits(result_t)),
    .Depth(OutDepth)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_word),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (outq_data),
    .empty_o(empty)
  );

  assign out_word        = result_t'(outq_data);
  assign oxygen_rate_o   = out_word.oxygen_rate;
  assign oxygen_slope_o  = out_word.oxygen_slope;
  assign vegf_rate_o     = out_word.vegf_rate;
  assign vegf_slope_o    = out_word.vegf_slope;
  assign linear_rate_o   = out_word.linear_rate;
  assign linear_slope_o  = out_word.linear_slope;
  assign hypoxic_rate_o  = out_word.hypoxic_rate;
  assign hypoxic_slope_o = out_word.hypoxic_slope;

  // The back end never writes into a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(res_push && res_full))
    else $error("result word written into a full queue");

  // The back end only takes words that are present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(inq_pop && inq_empty))
    else $error("front queue read while empty");

  // A stalled back end leaves the front queue alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_full |-> !inq_pop)
    else $error("front queue read while the pipeline is stalled");

endmodule
